// ===== rtl/u8dh_pkg.sv =====
package u8dh_pkg;

	localparam int unsigned CpWidth     = 21;
	localparam int unsigned ColourWidth = 8;
	localparam int unsigned CfgIdxWidth = 1;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxWidth-1:0] RegNormalColour    = 1'd0;
	localparam logic [CfgIdxWidth-1:0] RegHighlightColour = 1'd1;

	// Bytes with a special meaning at a lead position.
	localparam logic [7:0] ByteZero     = 8'h00;
	localparam logic [7:0] ByteAt       = 8'h40;
	localparam logic [7:0] ByteQuestion = 8'h3F;

	// Hangul syllable block.
	localparam logic [CpWidth-1:0] HangulFirst = 21'h00AC00;
	localparam logic [CpWidth-1:0] HangulLast  = 21'h00D7A3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic                   char_valid;
		logic [CpWidth-1:0]     code_point;
		logic                   in_highlight;
		logic [ColourWidth-1:0] glyph_colour;
		logic                   text_done;
	} out_item_t;

	// Push of a new result into the output buffer.
	typedef struct packed {
		logic      push;
		out_item_t item;
	} result_push_t;

	// True for code points that leave a highlight run open.
	function automatic logic keeps_highlight(input logic [CpWidth-1:0] cp);
		logic upper;
		logic lower;
		logic hangul;
		upper  = (cp >= 21'h41) && (cp <= 21'h5A);
		lower  = (cp >= 21'h61) && (cp <= 21'h7A);
		hangul = (cp >= HangulFirst) && (cp <= HangulLast);
		return upper || lower || hangul;
	endfunction

endpackage

// ===== rtl/utf8_decoder_with_highlight.sv =====
// An accepted byte's result is registered in the output buffer before it reaches out_valid.
// Throughput: one text byte per cycle while not stalled; decode state updates on transfer.
// A two-entry output buffer lets a byte transfer while a result waits to be taken.
// Reset (arst_n low, asynchronous) clears the decode state, both colours and the buffer.
module utf8_decoder_with_highlight (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  u8dh_pkg::in_item_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output u8dh_pkg::out_item_t                   out_data,
	input  logic                                  cfg_we,
	input  logic [u8dh_pkg::CfgIdxWidth-1:0]      cfg_index,
	input  logic [u8dh_pkg::ColourWidth-1:0]      cfg_data
);
	import u8dh_pkg::*;

	logic         accept;
	logic         buf_full;
	result_push_t result;

	// The input side is held off only when both output entries are occupied,
	// so a waiting result never blocks the next transfer by itself.
	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	// Decoder: sequence state, highlight tracking and the colour registers.
	// Bytes that produce no character and no end of text push nothing.
	u8dh_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	// Result register with a skid entry behind it.
	u8dh_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/u8dh_core.sv =====
module u8dh_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  u8dh_pkg::in_item_t                    item,
	input  logic                                  cfg_we,
	input  logic [u8dh_pkg::CfgIdxWidth-1:0]      cfg_index,
	input  logic [u8dh_pkg::ColourWidth-1:0]      cfg_data,
	output u8dh_pkg::result_push_t                result
);
	import u8dh_pkg::*;

	logic [CpWidth-1:0]     partial_q;
	logic [1:0]             pending_q;
	logic                   highlight_q;
	logic                   stopped_q;
	logic [ColourWidth-1:0] normal_colour_q;
	logic [ColourWidth-1:0] highlight_colour_q;

	logic [CpWidth-1:0]     partial_n;
	logic [1:0]             pending_n;
	logic                   highlight_n;
	logic                   stopped_n;
	logic                   have;
	logic [CpWidth-1:0]     cp;
	logic [CpWidth-1:0]     merged;
	logic [7:0]             b;

	assign b      = item.text_byte;
	assign merged = {partial_q[CpWidth-7:0], b[5:0]};

	always_comb begin
		partial_n   = partial_q;
		pending_n   = pending_q;
		highlight_n = highlight_q;
		stopped_n   = stopped_q;
		have        = 1'b0;
		cp          = '0;

		if (!stopped_q) begin
			if (pending_q == 2'd0) begin
				if (b == ByteZero) begin
					stopped_n = 1'b1;
				end else if (b == ByteAt) begin
					highlight_n = 1'b1;
				end else if (!b[7]) begin
					cp   = {13'd0, b};
					have = 1'b1;
				end else if (b[7:5] == 3'b110) begin
					partial_n = {16'd0, b[4:0]};
					pending_n = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					partial_n = {17'd0, b[3:0]};
					pending_n = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					partial_n = {18'd0, b[2:0]};
					pending_n = 2'd3;
				end else begin
					cp   = {13'd0, ByteQuestion};
					have = 1'b1;
				end
			end else if (b == ByteZero) begin
				// Terminator inside a sequence flushes what has been gathered.
				cp        = partial_q;
				have      = (partial_q != '0);
				partial_n = '0;
				pending_n = 2'd0;
				stopped_n = 1'b1;
			end else begin
				partial_n = merged;
				pending_n = pending_q - 2'd1;
				if (pending_n == 2'd0) begin
					cp        = merged;
					partial_n = '0;
					if (merged == '0) begin
						stopped_n = 1'b1;
					end else begin
						have = 1'b1;
					end
				end
			end
			if (item.end_of_text && (pending_n != 2'd0)) begin
				cp   = partial_n;
				have = (partial_n != '0);
			end
		end

		if (have && highlight_n && !keeps_highlight(cp)) begin
			highlight_n = 1'b0;
		end

		result.push              = accept && (have || item.end_of_text);
		result.item.char_valid   = have;
		result.item.code_point   = have ? cp : '0;
		result.item.in_highlight = have && highlight_n;
		result.item.glyph_colour = !have ? '0 :
			(highlight_n ? highlight_colour_q : normal_colour_q);
		result.item.text_done    = item.end_of_text;

		if (item.end_of_text) begin
			partial_n   = '0;
			pending_n   = 2'd0;
			highlight_n = 1'b0;
			stopped_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			pending_q   <= 2'd0;
			highlight_q <= 1'b0;
			stopped_q   <= 1'b0;
		end else if (accept) begin
			partial_q   <= partial_n;
			pending_q   <= pending_n;
			highlight_q <= highlight_n;
			stopped_q   <= stopped_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_colour_q    <= '0;
			highlight_colour_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegNormalColour: begin
					normal_colour_q <= cfg_data;
				end
				RegHighlightColour: begin
					highlight_colour_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/u8dh_outbuf.sv =====
module u8dh_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  u8dh_pkg::result_push_t result,
	output logic                   full,
	output logic                   out_valid,
	input  logic                   out_stall,
	output u8dh_pkg::out_item_t    out_data
);
	import u8dh_pkg::*;

	out_item_t main_q;
	out_item_t skid_q;
	logic      main_valid_q;
	logic      skid_valid_q;
	logic      pop;
	logic      main_free;

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign pop       = main_valid_q && !out_stall;
	assign main_free = !main_valid_q || (pop && !skid_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			main_valid_q <= result.push || skid_valid_q || (main_valid_q && !pop);
			skid_valid_q <= (skid_valid_q && !pop) || (result.push && !main_free);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end
		if (result.push) begin
			if (main_free) begin
				main_q <= result.item;
			end else begin
				skid_q <= result.item;
			end
		end
	end

endmodule
